FILE: hw/rtl/ftm_pkg.sv
package ftm_pkg;

  // fixed point format
  localparam int FRAC_BITS = 12;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int HALF_Q    = 1 << (FRAC_BITS - 1);

  // field widths
  localparam int DMD_W    = 14;
  localparam int THR_W    = 13;
  localparam int GAIN_W   = 14;
  localparam int THRUST_W = 13;
  localparam int APPL_W   = 14;
  localparam int UNC_W    = 15;
  localparam int TILT_W   = 16;

  // internal widths
  localparam int SUM_W   = DMD_W + 1;
  localparam int PROD_W  = SUM_W + GAIN_W + 1;
  localparam int AXIS_W  = PROD_W - FRAC_BITS;
  localparam int TPROD_W = THR_W + GAIN_W + 1;
  localparam int TSC_W   = TPROD_W - FRAC_BITS;
  localparam int MIX_W   = 20;
  localparam int MAG_W   = 16;
  localparam int QUO_W   = UNC_W - 1;
  localparam int DIV_W   = GAIN_W + QUO_W;

  // stream widths
  localparam int IN_W  = 112;
  localparam int OUT_W = 104;

  // queue between mixer and divider
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [DMD_W-1:0] roll_demand;
    logic signed [DMD_W-1:0] roll_feedforward;
    logic signed [DMD_W-1:0] pitch_demand;
    logic signed [DMD_W-1:0] pitch_feedforward;
    logic signed [DMD_W-1:0] yaw_demand;
    logic signed [DMD_W-1:0] yaw_feedforward;
    logic [THR_W-1:0]        throttle_demand;
    logic [GAIN_W-1:0]       comp_gain;
  } mix_req_t;

  // mixed item waiting for the throttle divide
  typedef struct packed {
    logic [THRUST_W-1:0]      left;
    logic [THRUST_W-1:0]      right;
    logic [THRUST_W-1:0]      front;
    logic [THRUST_W-1:0]      rear;
    logic signed [APPL_W-1:0] applied;
    logic signed [TILT_W-1:0] tilt;
    logic                     flag_low;
    logic                     flag_high;
    logic                     desat;
    logic                     neg;
    logic [DIV_W-1:0]         num;
    logic [GAIN_W-1:0]        gain;
  } mix_item_t;

  typedef struct packed {
    logic [THRUST_W-1:0]      thrust_left;
    logic [THRUST_W-1:0]      thrust_right;
    logic [THRUST_W-1:0]      thrust_front;
    logic [THRUST_W-1:0]      thrust_rear;
    logic signed [APPL_W-1:0] throttle_applied;
    logic signed [UNC_W-1:0]  throttle_uncompensated;
    logic signed [TILT_W-1:0] tilt_command;
    logic                     flag_throttle_low;
    logic                     flag_throttle_high;
    logic                     flag_roll_limit;
    logic                     flag_pitch_limit;
  } mix_result_t;

endpackage

FILE: hw/rtl/ftm_front.sv
module ftm_front import ftm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  output logic             req_ready,
  input  mix_req_t         req,
  input  logic [THR_W-1:0] ceiling,
  output logic             item_valid,
  input  logic             item_full,
  output mix_item_t        item
);

  localparam int APPL_MAX = (1 << (APPL_W - 1)) - 1;
  localparam int APPL_MIN = -(1 << (APPL_W - 1));
  localparam int TILT_MAX = (1 << (TILT_W - 1)) - 1;
  localparam int TILT_MIN = -(1 << (TILT_W - 1));

  // round to nearest, ties up
  function automatic logic signed [AXIS_W-1:0] gain_scale(
    input logic signed [SUM_W-1:0] a,
    input logic [GAIN_W-1:0] g
  );
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * $signed({1'b0, g}) + PROD_W'(HALF_Q);
    return AXIS_W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [TSC_W-1:0] thr_scale(
    input logic [THR_W-1:0] t,
    input logic [GAIN_W-1:0] g
  );
    logic [TPROD_W-1:0] p;
    p = TPROD_W'(t) * TPROD_W'(g) + TPROD_W'(HALF_Q);
    return TSC_W'(p >> FRAC_BITS);
  endfunction

  function automatic logic [THRUST_W-1:0] thrust_clamp(input logic signed [MIX_W-1:0] v);
    logic [THRUST_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > MIX_W'(ONE_Q)) begin
      r = THRUST_W'(ONE_Q);
    end else begin
      r = v[THRUST_W-1:0];
    end
    return r;
  endfunction

  logic front_en;

  // stage 1: axis sums
  logic                     s1_v_r;
  logic signed [SUM_W-1:0]  s1_roll_r, s1_pitch_r, s1_yaw_r;
  logic signed [SUM_W-1:0]  s1_roll_nxt, s1_pitch_nxt, s1_yaw_nxt;
  logic [THR_W-1:0]         s1_thr_r;
  logic [GAIN_W-1:0]        s1_gain_r;

  // stage 2: gain scaling
  logic                     s2_v_r;
  logic signed [AXIS_W-1:0] s2_roll_r, s2_pitch_r, s2_yaw_r;
  logic signed [AXIS_W-1:0] s2_roll_nxt, s2_pitch_nxt, s2_yaw_nxt;
  logic [TSC_W-1:0]         s2_thr_r, s2_thr_nxt;
  logic [GAIN_W-1:0]        s2_gain_r;

  // stage 3: throttle clamp and mix
  logic                     s3_v_r;
  logic signed [MIX_W-1:0]  s3_left_r, s3_right_r, s3_front_r, s3_rear_r;
  logic signed [MIX_W-1:0]  s3_left_nxt, s3_right_nxt, s3_front_nxt, s3_rear_nxt;
  logic [THR_W-1:0]         s3_thr_r, s3_thr_nxt;
  logic                     s3_low_r, s3_low_nxt, s3_high_r, s3_high_nxt;
  logic signed [AXIS_W-1:0] s3_yaw_r;
  logic [GAIN_W-1:0]        s3_gain_r;

  // stage 4: desaturation offset
  logic                     s4_v_r;
  logic signed [MIX_W-1:0]  s4_left_r, s4_right_r, s4_front_r, s4_rear_r;
  logic signed [MIX_W-1:0]  s4_adj_r, s4_adj_nxt;
  logic                     s4_desat_r, s4_desat_nxt;
  logic [THR_W-1:0]         s4_thr_r;
  logic                     s4_low_r, s4_high_r;
  logic signed [AXIS_W-1:0] s4_yaw_r;
  logic [GAIN_W-1:0]        s4_gain_r;

  // stage 5: apply offset, clamp, saturate
  logic                     s5_v_r;
  mix_item_t                s5_item_r, s5_item_nxt;

  // whole front moves together; holds only when the queue is full
  always_comb begin
    front_en  = !s5_v_r || !item_full;
    req_ready = front_en;
  end

  // stage 1 next values
  always_comb begin
    s1_roll_nxt  = SUM_W'(req.roll_demand) + SUM_W'(req.roll_feedforward);
    s1_pitch_nxt = SUM_W'(req.pitch_demand) + SUM_W'(req.pitch_feedforward);
    s1_yaw_nxt   = SUM_W'(req.yaw_demand) + SUM_W'(req.yaw_feedforward);
  end

  // stage 2 next values
  always_comb begin
    s2_roll_nxt  = gain_scale(s1_roll_r, s1_gain_r);
    s2_pitch_nxt = gain_scale(s1_pitch_r, s1_gain_r);
    s2_yaw_nxt   = gain_scale(s1_yaw_r, s1_gain_r);
    s2_thr_nxt   = thr_scale(s1_thr_r, s1_gain_r);
  end

  // stage 3 next values
  always_comb begin
    logic signed [MIX_W-1:0] thr_m;
    logic signed [MIX_W-1:0] roll_m;
    logic signed [MIX_W-1:0] half_pitch;
    s3_low_nxt  = (s2_thr_r == '0);
    s3_high_nxt = (s2_thr_r >= TSC_W'(ceiling));
    if (s3_low_nxt) begin
      s3_thr_nxt = '0;
    end else if (s3_high_nxt) begin
      s3_thr_nxt = ceiling;
    end else begin
      s3_thr_nxt = s2_thr_r[THR_W-1:0];
    end
    thr_m        = $signed(MIX_W'(s3_thr_nxt));
    roll_m       = MIX_W'(s2_roll_r);
    half_pitch   = MIX_W'(s2_pitch_r) >>> 1;
    s3_left_nxt  = (thr_m + roll_m) >>> 1;
    s3_right_nxt = (thr_m - roll_m) >>> 1;
    s3_front_nxt = thr_m + half_pitch;
    s3_rear_nxt  = thr_m - half_pitch;
  end

  // stage 4 next values
  always_comb begin
    logic signed [MIX_W-1:0] mx;
    mx           = (s3_left_r > s3_right_r) ? s3_left_r : s3_right_r;
    s4_desat_nxt = (mx > MIX_W'(ONE_Q));
    s4_adj_nxt   = s4_desat_nxt ? (MIX_W'(ONE_Q) - mx) : '0;
  end

  // stage 5 next values
  always_comb begin
    logic signed [MIX_W-1:0] applied_m;
    logic signed [MIX_W-1:0] abs_m;
    applied_m = $signed(MIX_W'(s4_thr_r)) + s4_adj_r;
    abs_m     = (applied_m < 0) ? -applied_m : applied_m;

    s5_item_nxt.left  = thrust_clamp(s4_left_r + s4_adj_r);
    s5_item_nxt.right = thrust_clamp(s4_right_r + s4_adj_r);
    s5_item_nxt.front = thrust_clamp(s4_front_r + s4_adj_r);
    s5_item_nxt.rear  = thrust_clamp(s4_rear_r + s4_adj_r);

    if (applied_m > MIX_W'(APPL_MAX)) begin
      s5_item_nxt.applied = APPL_W'(APPL_MAX);
    end else if (applied_m < MIX_W'(APPL_MIN)) begin
      s5_item_nxt.applied = APPL_W'(APPL_MIN);
    end else begin
      s5_item_nxt.applied = applied_m[APPL_W-1:0];
    end

    if (s4_yaw_r > AXIS_W'(TILT_MAX)) begin
      s5_item_nxt.tilt = TILT_W'(TILT_MAX);
    end else if (s4_yaw_r < AXIS_W'(TILT_MIN)) begin
      s5_item_nxt.tilt = TILT_W'(TILT_MIN);
    end else begin
      s5_item_nxt.tilt = s4_yaw_r[TILT_W-1:0];
    end

    s5_item_nxt.flag_low  = s4_low_r;
    s5_item_nxt.flag_high = s4_high_r || s4_desat_r;
    s5_item_nxt.desat     = s4_desat_r;
    s5_item_nxt.neg       = (applied_m < 0);
    s5_item_nxt.num       = DIV_W'({abs_m[MAG_W-1:0], {FRAC_BITS{1'b0}}});
    s5_item_nxt.gain      = s4_gain_r;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (front_en) begin
      s1_v_r <= req_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (front_en) begin
      s1_roll_r  <= s1_roll_nxt;
      s1_pitch_r <= s1_pitch_nxt;
      s1_yaw_r   <= s1_yaw_nxt;
      s1_thr_r   <= req.throttle_demand;
      s1_gain_r  <= req.comp_gain;

      s2_roll_r  <= s2_roll_nxt;
      s2_pitch_r <= s2_pitch_nxt;
      s2_yaw_r   <= s2_yaw_nxt;
      s2_thr_r   <= s2_thr_nxt;
      s2_gain_r  <= s1_gain_r;

      s3_left_r  <= s3_left_nxt;
      s3_right_r <= s3_right_nxt;
      s3_front_r <= s3_front_nxt;
      s3_rear_r  <= s3_rear_nxt;
      s3_thr_r   <= s3_thr_nxt;
      s3_low_r   <= s3_low_nxt;
      s3_high_r  <= s3_high_nxt;
      s3_yaw_r   <= s2_yaw_r;
      s3_gain_r  <= s2_gain_r;

      s4_left_r  <= s3_left_r;
      s4_right_r <= s3_right_r;
      s4_front_r <= s3_front_r;
      s4_rear_r  <= s3_rear_r;
      s4_adj_r   <= s4_adj_nxt;
      s4_desat_r <= s4_desat_nxt;
      s4_thr_r   <= s3_thr_r;
      s4_low_r   <= s3_low_r;
      s4_high_r  <= s3_high_r;
      s4_yaw_r   <= s3_yaw_r;
      s4_gain_r  <= s3_gain_r;

      s5_item_r  <= s5_item_nxt;
    end
  end

  assign item_valid = s5_v_r;
  assign item       = s5_item_r;

endmodule

FILE: hw/rtl/ftm_queue.sv
module ftm_queue import ftm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mix_item_t push_item,
  output logic      full,
  output logic      pop_valid,
  input  logic      pop,
  output mix_item_t pop_item
);

  mix_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

endmodule

FILE: hw/rtl/ftm_back.sv
module ftm_back import ftm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_pop,
  input  mix_item_t   item,
  output logic        res_valid,
  input  logic        res_ready,
  output mix_result_t res
);

  localparam int UNC_MAX = (1 << (UNC_W - 1)) - 1;
  localparam int UNC_MIN = -(1 << (UNC_W - 1));

  typedef struct packed {
    mix_item_t        item;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             ovf;
  } div_stage_t;

  logic        back_en;
  logic [QUO_W:0] v_r;
  div_stage_t  st_r   [QUO_W+1];
  div_stage_t  st_nxt [QUO_W+1];
  logic        res_valid_r;
  mix_result_t res_r, res_nxt;

  // back moves together; holds while the result waits
  always_comb begin
    back_en  = !res_valid_r || res_ready;
    item_pop = back_en && item_valid;
  end

  // entry stage: quotient overflow check
  always_comb begin
    st_nxt[0].item = item;
    st_nxt[0].rem  = item.num;
    st_nxt[0].quo  = '0;
    st_nxt[0].ovf  = (item.num >= {item.gain, {QUO_W{1'b0}}});
  end

  // one quotient bit per stage, restoring
  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    localparam int B = QUO_W - k;
    always_comb begin
      logic [DIV_W-1:0] trial;
      trial     = DIV_W'(st_r[k-1].item.gain) << B;
      st_nxt[k] = st_r[k-1];
      if (st_r[k-1].rem >= trial) begin
        st_nxt[k].rem    = st_r[k-1].rem - trial;
        st_nxt[k].quo[B] = 1'b1;
      end
    end
  end

  // result assembly with sign and saturation
  always_comb begin
    div_stage_t        last;
    logic [UNC_W-1:0]  q_ext;
    last  = st_r[QUO_W];
    q_ext = UNC_W'(last.quo);
    res_nxt.thrust_left        = last.item.left;
    res_nxt.thrust_right       = last.item.right;
    res_nxt.thrust_front       = last.item.front;
    res_nxt.thrust_rear        = last.item.rear;
    res_nxt.throttle_applied   = last.item.applied;
    res_nxt.tilt_command       = last.item.tilt;
    res_nxt.flag_throttle_low  = last.item.flag_low;
    res_nxt.flag_throttle_high = last.item.flag_high;
    res_nxt.flag_roll_limit    = last.item.desat;
    res_nxt.flag_pitch_limit   = last.item.desat;
    if (last.item.gain == '0) begin
      res_nxt.throttle_uncompensated = '0;
    end else if (last.ovf) begin
      res_nxt.throttle_uncompensated = last.item.neg ? UNC_W'(UNC_MIN) : UNC_W'(UNC_MAX);
    end else begin
      res_nxt.throttle_uncompensated = last.item.neg ? $signed(-q_ext) : $signed(q_ext);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      res_valid_r <= 1'b0;
    end else if (back_en) begin
      v_r         <= {v_r[QUO_W-1:0], item_valid};
      res_valid_r <= v_r[QUO_W];
    end
  end

  // divider stage and output payloads
  always_ff @(posedge clk) begin
    if (back_en) begin
      st_r  <= st_nxt;
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: hw/rtl/four_motor_thrust_mixer.sv
// Four-motor thrust mixer with desaturation, Q12 fixed point (4096 = 1.0). Each
// in_tdata transfer carries roll, pitch and yaw demands with feed-forward terms,
// a throttle and a compensation gain; each one yields exactly one out_tdata
// transfer, in order. Throughput is one item per clock while out_tready stays high. An
// input transfer passes through five mixer stages, the four-entry queue, fifteen
// stages of the throttle divider (an overflow check, then one quotient bit per
// stage) and the output register.
// The mixer and the divider stall independently; in_tready drops only when the
// queue is full. cfg_ready is always high and throttle_ceiling resets to 4096;
// write it only while no item is in flight.
module four_motor_thrust_mixer import ftm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // roll_demand, roll_feedforward, pitch_demand, pitch_feedforward,
  // yaw_demand, yaw_feedforward, throttle_demand, comp_gain, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // thrust_left, thrust_right, thrust_front, thrust_rear, throttle_applied,
  // throttle_uncompensated, tilt_command, flag_throttle_low,
  // flag_throttle_high, flag_roll_limit, flag_pitch_limit, zero pad
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic [THR_W-1:0] cfg_data,
  input  logic             cfg_valid,
  output logic             cfg_ready
);

  logic [THR_W-1:0] ceiling_r;
  mix_req_t         req;
  logic             f_valid;
  mix_item_t        f_item;
  logic             q_push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  mix_item_t        q_item;
  mix_result_t      res;

  // throttle ceiling register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= THR_W'(ONE_Q);
    end else if (cfg_valid && cfg_ready) begin
      ceiling_r <= cfg_data;
    end
  end

  // input field unpack
  always_comb begin
    req.roll_demand       = $signed(in_tdata[13:0]);
    req.roll_feedforward  = $signed(in_tdata[27:14]);
    req.pitch_demand      = $signed(in_tdata[41:28]);
    req.pitch_feedforward = $signed(in_tdata[55:42]);
    req.yaw_demand        = $signed(in_tdata[69:56]);
    req.yaw_feedforward   = $signed(in_tdata[83:70]);
    req.throttle_demand   = in_tdata[96:84];
    req.comp_gain         = in_tdata[110:97];
  end

  ftm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req        (req),
    .ceiling    (ceiling_r),
    .item_valid (f_valid),
    .item_full  (q_full),
    .item       (f_item)
  );

  assign q_push = f_valid && !q_full;

  ftm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  ftm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_pop   (q_pop),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // result pack
  assign out_tdata = {3'b000,
                      res.flag_pitch_limit, res.flag_roll_limit,
                      res.flag_throttle_high, res.flag_throttle_low,
                      res.tilt_command, res.throttle_uncompensated,
                      res.throttle_applied, res.thrust_rear, res.thrust_front,
                      res.thrust_right, res.thrust_left};

  // thrusts never leave zero to one
  a_thrust_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.thrust_left <= THRUST_W'(ONE_Q)) &&
                   (res.thrust_right <= THRUST_W'(ONE_Q)) &&
                   (res.thrust_front <= THRUST_W'(ONE_Q)) &&
                   (res.thrust_rear <= THRUST_W'(ONE_Q)))
    else $error("thrust above full scale");

  // desaturation always raises the throttle-high flag
  a_desat_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.flag_roll_limit |-> res.flag_throttle_high && res.flag_pitch_limit)
    else $error("limit flags inconsistent");

  // input stalls only behind a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_full && f_valid)
    else $error("input stalled without a full queue");

  // queue drains when the divider side is free
  a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && (!out_tvalid || out_tready) |-> q_pop)
    else $error("queue not drained");

endmodule
